[rtl/mbe_pkg.sv]
// Shared constants, types and helpers of the Mandelbrot escape-time block.
// Used by mbe_ctrl, mbe_datapath and mandelbrot_escape_time; no dependencies.
package mbe_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 26;
    localparam int ITER_BITS  = 20;
    localparam int WORD_BITS  = 32;
    localparam int PROD_BITS  = 2 * WORD_BITS;

    // |z|^2 >= 4 in the scale of a raw square sum
    localparam int ESC_SHIFT = 2 * FRAC_BITS + 2;

    localparam int IN_BITS     = 2 * COORD_BITS;
    localparam int IN_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = ITER_BITS + 1 + 2 * COORD_BITS;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    localparam int CFG_IDX_BITS = 3;

    localparam logic signed [WORD_BITS-1:0] LEFT_REAL_RST   = -32'sd134217728;
    localparam logic signed [WORD_BITS-1:0] BOTTOM_IMAG_RST = -32'sd134217728;
    localparam logic signed [WORD_BITS-1:0] X_STEP_RST      = 32'sd262144;
    localparam logic signed [WORD_BITS-1:0] Y_STEP_RST      = 32'sd262144;
    localparam logic [ITER_BITS-1:0]        MAX_ITER_RST    = 20'd100000;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_LEFT_REAL   = 3'd0,
        CFG_BOTTOM_IMAG = 3'd1,
        CFG_X_STEP      = 3'd2,
        CFG_Y_STEP      = 3'd3,
        CFG_MAX_ITER    = 3'd4
    } cfg_index_t;

    typedef enum logic [2:0] {
        MS_CRE,
        MS_CIM,
        MS_RR,
        MS_II,
        MS_RI
    } mul_sel_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CRE,
        ST_CIM,
        ST_CAPI,
        ST_ZRR,
        ST_ZII,
        ST_ZRI,
        ST_UPD,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic     start;
        mul_sel_t mul_sel;
        logic     cap_cr;
        logic     cap_ci;
        logic     cap_rr;
        logic     cap_ii;
        logic     step;
        logic     emit;
    } mbe_cmd_t;

    typedef struct packed {
        logic stop;
        logic out_busy;
    } mbe_status_t;

    // clamp a wide signed value into one signed word
    function automatic logic signed [WORD_BITS-1:0] sat_word(
        input logic signed [PROD_BITS-1:0] x
    );
        logic signed [WORD_BITS-1:0] r;
        if (x[PROD_BITS-1] == 1'b0 && x[PROD_BITS-2:WORD_BITS-1] != '0) begin
            r = {1'b0, {(WORD_BITS-1){1'b1}}};
        end else if (x[PROD_BITS-1] == 1'b1 && x[PROD_BITS-2:WORD_BITS-1] != '1) begin
            r = {1'b1, {(WORD_BITS-1){1'b0}}};
        end else begin
            r = x[WORD_BITS-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/mbe_ctrl.sv]
// Sequencer of the escape-time block: accepts a request, steps the shared
// multiplier through the iteration and hands the result to the output register.
// Depends on mbe_pkg.
module mbe_ctrl
    import mbe_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  mbe_status_t status,
    output mbe_cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.mul_sel   = MS_RR;
        s_axis_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_CRE;
                end
            end
            ST_CRE:
            begin
                cmd.mul_sel = MS_CRE;
                state_next  = ST_CIM;
            end
            ST_CIM:
            begin
                cmd.mul_sel = MS_CIM;
                cmd.cap_cr  = 1'b1;
                state_next  = ST_CAPI;
            end
            ST_CAPI:
            begin
                cmd.cap_ci = 1'b1;
                state_next = ST_ZRR;
            end
            ST_ZRR:
            begin
                cmd.mul_sel = MS_RR;
                state_next  = ST_ZII;
            end
            ST_ZII:
            begin
                cmd.mul_sel = MS_II;
                cmd.cap_rr  = 1'b1;
                state_next  = ST_ZRI;
            end
            ST_ZRI:
            begin
                cmd.mul_sel = MS_RI;
                cmd.cap_ii  = 1'b1;
                state_next  = ST_UPD;
            end
            ST_UPD:
            begin
                if (status.stop)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_ZRR;
                end
            end
            ST_FINISH:
            begin
                // hold until the output register can take the result
                if (!status.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> state_reg == ST_CRE)
        else $error("accepted request did not start the sequence");
`endif

endmodule

[rtl/mbe_datapath.sv]
// Datapath of the escape-time block: configuration registers, the shared
// 32x32 multiplier, z update with saturation, escape test and output register.
// Depends on mbe_pkg.
module mbe_datapath
    import mbe_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [WORD_BITS-1:0]    cfg_data,
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
    input  mbe_cmd_t                cmd,
    output mbe_status_t             status,
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata
);

    logic signed [WORD_BITS-1:0] left_real_reg;
    logic signed [WORD_BITS-1:0] bottom_imag_reg;
    logic signed [WORD_BITS-1:0] x_step_reg;
    logic signed [WORD_BITS-1:0] y_step_reg;
    logic [ITER_BITS-1:0]        max_iter_reg;

    logic [COORD_BITS-1:0]       col_reg;
    logic [COORD_BITS-1:0]       row_reg;
    logic signed [WORD_BITS-1:0] cr_reg;
    logic signed [WORD_BITS-1:0] ci_reg;
    logic signed [WORD_BITS-1:0] zr_reg;
    logic signed [WORD_BITS-1:0] zi_reg;
    logic signed [PROD_BITS-1:0] prod_reg;
    logic signed [PROD_BITS-1:0] rr_reg;
    logic signed [PROD_BITS-1:0] ii_reg;
    logic [ITER_BITS-1:0]        count_reg;

    logic                        out_valid_reg;
    logic [ITER_BITS-1:0]        out_iter_reg;
    logic                        out_inside_reg;
    logic [COORD_BITS-1:0]       out_col_reg;
    logic [COORD_BITS-1:0]       out_row_reg;

    logic signed [WORD_BITS-1:0] mul_a;
    logic signed [WORD_BITS-1:0] mul_b;
    logic [ITER_BITS-1:0]        limit;
    logic [PROD_BITS-1:0]        mag_sum;
    logic                        escaped;
    logic signed [PROD_BITS-1:0] diff;
    logic signed [PROD_BITS-1:0] nr_full;
    logic signed [PROD_BITS-1:0] ni_full;
    logic signed [PROD_BITS-1:0] c_edge_sum;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_real_reg   <= LEFT_REAL_RST;
            bottom_imag_reg <= BOTTOM_IMAG_RST;
            x_step_reg      <= X_STEP_RST;
            y_step_reg      <= Y_STEP_RST;
            max_iter_reg    <= MAX_ITER_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LEFT_REAL:   left_real_reg   <= cfg_data;
                CFG_BOTTOM_IMAG: bottom_imag_reg <= cfg_data;
                CFG_X_STEP:      x_step_reg      <= cfg_data;
                CFG_Y_STEP:      y_step_reg      <= cfg_data;
                CFG_MAX_ITER:    max_iter_reg    <= cfg_data[ITER_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // operand selection for the shared multiplier
    always_comb
    begin
        unique case (cmd.mul_sel)
            MS_CRE:
            begin
                mul_a = {{(WORD_BITS-COORD_BITS){1'b0}}, col_reg};
                mul_b = x_step_reg;
            end
            MS_CIM:
            begin
                mul_a = {{(WORD_BITS-COORD_BITS){1'b0}}, row_reg};
                mul_b = y_step_reg;
            end
            MS_RR:
            begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
            MS_II:
            begin
                mul_a = zi_reg;
                mul_b = zi_reg;
            end
            MS_RI:
            begin
                mul_a = zr_reg;
                mul_b = zi_reg;
            end
            default:
            begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
        endcase
    end

    // window edge plus scaled coordinate; the product holds the scaled part
    assign c_edge_sum = prod_reg + PROD_BITS'(cmd.cap_cr ? left_real_reg : bottom_imag_reg);

    // squares are never negative, so the sum fits unsigned
    assign mag_sum = rr_reg + ii_reg;
    assign escaped = (mag_sum[PROD_BITS-1:ESC_SHIFT] != '0);
    assign limit   = (max_iter_reg == '0) ? ITER_BITS'(1) : max_iter_reg;

    // prod_reg holds zr*zi during the update cycle
    assign diff    = rr_reg - ii_reg;
    assign nr_full = (diff >>> FRAC_BITS) + PROD_BITS'(cr_reg);
    assign ni_full = (prod_reg >>> (FRAC_BITS - 1)) + PROD_BITS'(ci_reg);

    assign status.stop     = escaped || (count_reg >= limit);
    assign status.out_busy = out_valid_reg && !m_axis_tready;

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (cmd.start)
        begin
            col_reg <= s_axis_tdata[COORD_BITS-1:0];
            row_reg <= s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
        end
        if (cmd.cap_cr)
        begin
            cr_reg <= sat_word(c_edge_sum);
        end
        if (cmd.cap_ci)
        begin
            ci_reg <= sat_word(c_edge_sum);
        end
        if (cmd.cap_rr)
        begin
            rr_reg <= prod_reg;
        end
        if (cmd.cap_ii)
        begin
            ii_reg <= prod_reg;
        end
        if (cmd.start)
        begin
            zr_reg <= '0;
            zi_reg <= '0;
        end
        else if (cmd.step)
        begin
            zr_reg <= sat_word(nr_full);
            zi_reg <= sat_word(ni_full);
        end
        if (cmd.emit)
        begin
            out_iter_reg   <= count_reg;
            out_inside_reg <= !escaped;
            out_col_reg    <= col_reg;
            out_row_reg    <= row_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.start)
            begin
                count_reg <= '0;
            end
            else if (cmd.step)
            begin
                count_reg <= count_reg + ITER_BITS'(1);
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_BITS){1'b0}},
                            out_row_reg, out_col_reg, out_inside_reg, out_iter_reg};

`ifndef SYNTHESIS
    a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || m_axis_tready))
        else $error("result overwrote a waiting result");
    a_inside_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && !escaped) |-> count_reg == limit)
        else $error("inside result before the iteration limit");
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> count_reg < limit)
        else $error("iteration past the limit");
    a_result_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> count_reg != '0)
        else $error("result with zero iterations");
`endif

endmodule

[rtl/mandelbrot_escape_time.sv]
// Top level of the Mandelbrot escape-time block: sequencer plus datapath.
// Depends on mbe_pkg, mbe_ctrl and mbe_datapath.
//
//   channel  | direction | payload (low bit up)
//   ---------+-----------+------------------------------------------------
//   s_axis   | in        | tdata: col[11:0], row[23:12]
//   m_axis   | out       | tdata: iterations[19:0], inside_res[20],
//            |           |        col_tag[32:21], row_tag[44:33]
//   cfg      | in        | cfg_we, cfg_index, cfg_data (write only)
//
// One pixel at a time. Each iteration passes through the states ZRR, ZII,
// ZRI and UPD: the single 32x32 multiplier forms zr*zr, zi*zi and zr*zi in
// turn, then the z update and escape test follow.
// Reset is asynchronous, active low, and restores the default window.
// A new request is taken as soon as the previous pixel is handed to the
// output register, even while that result still waits on m_axis_tready.
module mandelbrot_escape_time
    import mbe_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [WORD_BITS-1:0]    cfg_data,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [IN_TDATA_W-1:0]   s_axis_tdata,    // col, row
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata     // iterations, inside_res, col_tag, row_tag
);

    mbe_cmd_t    cmd;
    mbe_status_t status;

    mbe_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .status        (status),
        .cmd           (cmd)
    );

    mbe_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tdata  (s_axis_tdata),
        .cmd           (cmd),
        .status        (status),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule
